FILE: design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FGN_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is high.
`define FGN_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

FILE: design/fgn_pkg.sv
package fgn_pkg;

   localparam int DEF_TABLE_DEPTH = 256;
   localparam int DEF_MAX_OCTAVES = 16;

   localparam int FRAC_BITS = 16;
   localparam int PROD_FRAC = 24;

   localparam int COORD_IN_W = 32;
   localparam int COORD_W    = FRAC_BITS + 1;
   localparam int GRAD_W     = FRAC_BITS + 3;
   localparam int LERP_W     = FRAC_BITS + 4;
   localparam int FADE_W     = FRAC_BITS + 2;
   localparam int MUL_A_W    = 33;
   localparam int MUL_B_W    = 22;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int SUM_W      = 34;
   localparam int NOISE_W    = 28;
   localparam int CFG_W      = 16;
   localparam int OCT_CFG_W  = 5;
   localparam int HASH_SLOTS = 14;
   localparam int STEP_W     = 4;
   localparam int AMP_SHIFT  = 8;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   localparam logic [1:0] CSR_DIMENSION_MODE  = 2'd0;
   localparam logic [1:0] CSR_OCTAVE_COUNT    = 2'd1;
   localparam logic [1:0] CSR_START_FREQUENCY = 2'd2;
   localparam logic [1:0] CSR_START_AMPLITUDE = 2'd3;

   localparam logic [MUL_B_W-1:0] FADE_TEN = MUL_B_W'(10 << FRAC_BITS);

   localparam logic signed [SUM_W-1:0] NOISE_MAX = SUM_W'(134217727);
   localparam logic signed [SUM_W-1:0] NOISE_MIN = -SUM_W'(134217728);

   // 12-direction edge gradient of the improved scheme.
   function automatic logic signed [GRAD_W-1:0] grad3(
      input logic [3:0]                h,
      input logic signed [COORD_W-1:0] x,
      input logic signed [COORD_W-1:0] y,
      input logic signed [COORD_W-1:0] z
   );
      logic signed [GRAD_W-1:0] xe;
      logic signed [GRAD_W-1:0] ye;
      logic signed [GRAD_W-1:0] ze;
      logic signed [GRAD_W-1:0] u;
      logic signed [GRAD_W-1:0] v;
      xe = {{(GRAD_W-COORD_W){x[COORD_W-1]}}, x};
      ye = {{(GRAD_W-COORD_W){y[COORD_W-1]}}, y};
      ze = {{(GRAD_W-COORD_W){z[COORD_W-1]}}, z};
      u  = (h < 4'd8) ? xe : ye;
      if (h < 4'd4) begin
         v = ye;
      end else if (h == 4'd12 || h == 4'd14) begin
         v = xe;
      end else begin
         v = ze;
      end
      grad3 = (h[0] ? -u : u) + (h[1] ? -v : v);
   endfunction

   // Four diagonal gradients for the planar mode.
   function automatic logic signed [GRAD_W-1:0] grad2(
      input logic [1:0]                h,
      input logic signed [COORD_W-1:0] x,
      input logic signed [COORD_W-1:0] y
   );
      logic signed [GRAD_W-1:0] xe;
      logic signed [GRAD_W-1:0] ye;
      xe = {{(GRAD_W-COORD_W){x[COORD_W-1]}}, x};
      ye = {{(GRAD_W-COORD_W){y[COORD_W-1]}}, y};
      case (h)
         2'd0:    grad2 = xe + ye;
         2'd1:    grad2 = ye - xe;
         2'd2:    grad2 = -xe - ye;
         default: grad2 = xe - ye;
      endcase
   endfunction

endpackage

FILE: design/fractal_gradient_noise.sv
// Channel  Direction  Handshake           Payload
// req_     in         req_valid/req_stall req_cmd, req_table_index, req_table_value,
//                                         req_coord_x, req_coord_y, req_coord_z
// rsp_     out        rsp_valid/rsp_stall rsp_noise_value
// csr_     in         csr_wr_en           csr_index, csr_wdata
//
// A table write word leaves req_stall low.
// An evaluate word works through its N octaves (N = octaves) in turn in 3D and 2D mode,
// sequenced around the single shared multiplier and the one-port table read; when N is
// zero it goes straight to the result.
// req_stall stays high from the evaluate word until its result is loaded into the
// output register; a stalled result holds there while the next word is taken.
// Reset is synchronous, active high; it clears control and restores the configuration defaults.
module fractal_gradient_noise #(
   parameter int TABLE_DEPTH = fgn_pkg::DEF_TABLE_DEPTH,
   parameter int MAX_OCTAVES = fgn_pkg::DEF_MAX_OCTAVES
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_cmd,
   input  logic [7:0]                             req_table_index,
   input  logic [7:0]                             req_table_value,
   input  logic signed [fgn_pkg::COORD_IN_W-1:0]  req_coord_x,
   input  logic signed [fgn_pkg::COORD_IN_W-1:0]  req_coord_y,
   input  logic signed [fgn_pkg::COORD_IN_W-1:0]  req_coord_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [fgn_pkg::NOISE_W-1:0]     rsp_noise_value,
   input  logic                                   csr_wr_en,
   input  logic [1:0]                             csr_index,
   input  logic [fgn_pkg::CFG_W-1:0]              csr_wdata
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int MW = fgn_pkg::PROD_FRAC + IW;
   localparam int KW = $clog2(MAX_OCTAVES + 1);
   localparam int FB = fgn_pkg::FRAC_BITS;
   localparam int LW = fgn_pkg::LERP_W;
   localparam int FW = fgn_pkg::FADE_W;
   localparam int SW = fgn_pkg::SUM_W;
   localparam int CW = fgn_pkg::COORD_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCALE, ST_FADE, ST_HRD, ST_HWB, ST_LERP, ST_AMP, ST_DONE
   } state_type;

   // Control and configuration.
   state_type                         state_ff, state_in;
   logic                              dim_ff, dim_in;
   logic [fgn_pkg::OCT_CFG_W-1:0]     oct_cfg_ff, oct_cfg_in;
   logic [fgn_pkg::CFG_W-1:0]         freq_ff, freq_in;
   logic [fgn_pkg::CFG_W-1:0]         amp_ff, amp_in;
   logic [fgn_pkg::STEP_W-1:0]        step_ff, step_in;
   logic [1:0]                        phase_ff, phase_in;
   logic [KW-1:0]                     k_ff, k_in;
   logic [KW-1:0]                     noct_ff, noct_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   // Datapath.
   logic signed [fgn_pkg::COORD_IN_W-1:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [MW-1:0]                     mx_ff, mx_in, my_ff, my_in, mz_ff, mz_in;
   logic [FB-1:0]                     t2_ff, t2_in, t3_ff, t3_in;
   logic [FW-1:0]                     fu_ff, fu_in, fv_ff, fv_in, fw_ff, fw_in;
   logic [7:0]                        hv_ff [fgn_pkg::HASH_SLOTS];
   logic [7:0]                        hv_in [fgn_pkg::HASH_SLOTS];
   logic signed [LW-1:0]              e0_ff, e0_in, e1_ff, e1_in, e2_ff, e2_in;
   logic signed [LW-1:0]              e3_ff, e3_in, f0_ff, f0_in, f1_ff, f1_in;
   logic signed [LW-1:0]              n_ff, n_in;
   logic signed [SW-1:0]              sum_ff, sum_in;
   logic signed [fgn_pkg::NOISE_W-1:0] rsp_value_ff, rsp_value_in;

   // Permutation table.
   logic [7:0]    perm_mem [TABLE_DEPTH];
   logic [7:0]    perm_q_ff;
   logic [IW-1:0] rd_addr;
   logic          mem_we;

   // Shared multiplier.
   logic signed [fgn_pkg::MUL_A_W-1:0] mul_a;
   logic signed [fgn_pkg::MUL_B_W-1:0] mul_b;
   logic signed [fgn_pkg::PROD_W-1:0]  prod;

   logic [IW-1:0]          cell_x, cell_y, cell_z;
   logic [FB-1:0]          fx, fy, fz;
   logic signed [CW-1:0]   x0, x1, y0, y1, z0, z1;
   logic [FB-1:0]          t_sel;
   logic [fgn_pkg::MUL_B_W-1:0] fade_p;
   logic signed [LW-1:0]   g [8];
   logic [FW-1:0]          lerp_t;
   logic signed [LW-1:0]   lerp_lo, lerp_hi, lerp_res;
   logic signed [LW:0]     lerp_diff;
   logic [5:0]             amp_shamt;
   logic [fgn_pkg::STEP_W-1:0] last_scale, last_hash, last_lerp;
   logic                   rsp_free;

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_value_ff;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Scaled coordinate: cell above the product's binary point, fraction below.
   assign cell_x = mx_ff[MW-1 -: IW];
   assign cell_y = my_ff[MW-1 -: IW];
   assign cell_z = mz_ff[MW-1 -: IW];
   assign fx     = mx_ff[fgn_pkg::PROD_FRAC-1 -: FB];
   assign fy     = my_ff[fgn_pkg::PROD_FRAC-1 -: FB];
   assign fz     = mz_ff[fgn_pkg::PROD_FRAC-1 -: FB];

   // Corner offsets: the far corner is the fraction minus one.
   assign x0 = $signed({1'b0, fx});
   assign x1 = $signed({1'b1, fx});
   assign y0 = $signed({1'b0, fy});
   assign y1 = $signed({1'b1, fy});
   assign z0 = $signed({1'b0, fz});
   assign z1 = $signed({1'b1, fz});

   assign last_scale = dim_ff ? fgn_pkg::STEP_W'(1) : fgn_pkg::STEP_W'(2);
   assign last_hash  = dim_ff ? fgn_pkg::STEP_W'(5) : fgn_pkg::STEP_W'(13);
   assign last_lerp  = dim_ff ? fgn_pkg::STEP_W'(2) : fgn_pkg::STEP_W'(6);

   // Corner gradients; the planar mode uses the first four places.
   always_comb begin
      if (dim_ff) begin
         g[0] = LW'(fgn_pkg::grad2(hv_ff[2][1:0], x0, y0));
         g[1] = LW'(fgn_pkg::grad2(hv_ff[3][1:0], x0, y1));
         g[2] = LW'(fgn_pkg::grad2(hv_ff[4][1:0], x1, y0));
         g[3] = LW'(fgn_pkg::grad2(hv_ff[5][1:0], x1, y1));
         g[4] = '0;
         g[5] = '0;
         g[6] = '0;
         g[7] = '0;
      end else begin
         g[0] = LW'(fgn_pkg::grad3(hv_ff[6][3:0],  x0, y0, z0));
         g[1] = LW'(fgn_pkg::grad3(hv_ff[7][3:0],  x1, y0, z0));
         g[2] = LW'(fgn_pkg::grad3(hv_ff[8][3:0],  x0, y1, z0));
         g[3] = LW'(fgn_pkg::grad3(hv_ff[9][3:0],  x1, y1, z0));
         g[4] = LW'(fgn_pkg::grad3(hv_ff[10][3:0], x0, y0, z1));
         g[5] = LW'(fgn_pkg::grad3(hv_ff[11][3:0], x1, y0, z1));
         g[6] = LW'(fgn_pkg::grad3(hv_ff[12][3:0], x0, y1, z1));
         g[7] = LW'(fgn_pkg::grad3(hv_ff[13][3:0], x1, y1, z1));
      end
   end

   // Interpolation schedule: four x lerps, two y lerps, one z lerp in 3D;
   // two y lerps then one x lerp in 2D.
   always_comb begin
      lerp_t  = fu_ff;
      lerp_lo = e0_ff;
      lerp_hi = e1_ff;
      if (dim_ff) begin
         case (step_ff)
            4'd0:    begin lerp_t = fv_ff; lerp_lo = g[0]; lerp_hi = g[1]; end
            4'd1:    begin lerp_t = fv_ff; lerp_lo = g[2]; lerp_hi = g[3]; end
            default: begin lerp_t = fu_ff; lerp_lo = e0_ff; lerp_hi = e1_ff; end
         endcase
      end else begin
         case (step_ff)
            4'd0:    begin lerp_t = fu_ff; lerp_lo = g[0]; lerp_hi = g[1]; end
            4'd1:    begin lerp_t = fu_ff; lerp_lo = g[2]; lerp_hi = g[3]; end
            4'd2:    begin lerp_t = fu_ff; lerp_lo = g[4]; lerp_hi = g[5]; end
            4'd3:    begin lerp_t = fu_ff; lerp_lo = g[6]; lerp_hi = g[7]; end
            4'd4:    begin lerp_t = fv_ff; lerp_lo = e0_ff; lerp_hi = e1_ff; end
            4'd5:    begin lerp_t = fv_ff; lerp_lo = e2_ff; lerp_hi = e3_ff; end
            default: begin lerp_t = fw_ff; lerp_lo = f0_ff; lerp_hi = f1_ff; end
         endcase
      end
   end

   assign lerp_diff = {lerp_hi[LW-1], lerp_hi} - {lerp_lo[LW-1], lerp_lo};
   assign lerp_res  = lerp_lo + LW'(prod >>> FB);

   // Fade operand and polynomial 6t^2 - 15t + 10 in fixed point.
   always_comb begin
      case (step_ff)
         4'd0:    t_sel = fx;
         4'd1:    t_sel = fy;
         default: t_sel = fz;
      endcase
   end

   assign fade_p = fgn_pkg::MUL_B_W'(6) * fgn_pkg::MUL_B_W'(t2_ff) + fgn_pkg::FADE_TEN
                 - fgn_pkg::MUL_B_W'(15) * fgn_pkg::MUL_B_W'(t_sel);

   // Operand select for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SCALE: begin
            case (step_ff)
               4'd0:    mul_a = {cx_ff[fgn_pkg::COORD_IN_W-1], cx_ff};
               4'd1:    mul_a = {cy_ff[fgn_pkg::COORD_IN_W-1], cy_ff};
               default: mul_a = {cz_ff[fgn_pkg::COORD_IN_W-1], cz_ff};
            endcase
            mul_b = {{(fgn_pkg::MUL_B_W-fgn_pkg::CFG_W){1'b0}}, freq_ff};
         end
         ST_FADE: begin
            case (phase_ff)
               2'd0: begin
                  mul_a = {{(fgn_pkg::MUL_A_W-FB){1'b0}}, t_sel};
                  mul_b = {{(fgn_pkg::MUL_B_W-FB){1'b0}}, t_sel};
               end
               2'd1: begin
                  mul_a = {{(fgn_pkg::MUL_A_W-FB){1'b0}}, t2_ff};
                  mul_b = {{(fgn_pkg::MUL_B_W-FB){1'b0}}, t_sel};
               end
               default: begin
                  mul_a = {{(fgn_pkg::MUL_A_W-FB){1'b0}}, t3_ff};
                  mul_b = fade_p;
               end
            endcase
         end
         ST_LERP: begin
            mul_a = {{(fgn_pkg::MUL_A_W-LW-1){lerp_diff[LW]}}, lerp_diff};
            mul_b = {{(fgn_pkg::MUL_B_W-FW){1'b0}}, lerp_t};
         end
         ST_AMP: begin
            mul_a = {{(fgn_pkg::MUL_A_W-LW){n_ff[LW-1]}}, n_ff};
            mul_b = {{(fgn_pkg::MUL_B_W-fgn_pkg::CFG_W){1'b0}}, amp_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod      = mul_a * mul_b;
   assign amp_shamt = 6'(fgn_pkg::AMP_SHIFT) + 6'(k_ff);

   // Hash read schedule: the two x-row entries, then the y-level entries, then
   // the eight corner hashes (3D only).
   always_comb begin
      case (step_ff)
         4'd0:    rd_addr = cell_x;
         4'd1:    rd_addr = cell_x + IW'(1);
         4'd2:    rd_addr = IW'(hv_ff[0]) + cell_y;
         4'd3:    rd_addr = IW'(hv_ff[0]) + cell_y + IW'(1);
         4'd4:    rd_addr = IW'(hv_ff[1]) + cell_y;
         4'd5:    rd_addr = IW'(hv_ff[1]) + cell_y + IW'(1);
         4'd6:    rd_addr = IW'(hv_ff[2]) + cell_z;
         4'd7:    rd_addr = IW'(hv_ff[4]) + cell_z;
         4'd8:    rd_addr = IW'(hv_ff[3]) + cell_z;
         4'd9:    rd_addr = IW'(hv_ff[5]) + cell_z;
         4'd10:   rd_addr = IW'(hv_ff[2]) + cell_z + IW'(1);
         4'd11:   rd_addr = IW'(hv_ff[4]) + cell_z + IW'(1);
         4'd12:   rd_addr = IW'(hv_ff[3]) + cell_z + IW'(1);
         default: rd_addr = IW'(hv_ff[5]) + cell_z + IW'(1);
      endcase
   end

   assign mem_we = (state_ff == ST_IDLE) && req_valid && (req_cmd == fgn_pkg::CMD_WRITE);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         perm_mem[IW'(req_table_index)] <= req_table_value;
      end
      perm_q_ff <= perm_mem[rd_addr];
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      dim_in       = dim_ff;
      oct_cfg_in   = oct_cfg_ff;
      freq_in      = freq_ff;
      amp_in       = amp_ff;
      step_in      = step_ff;
      phase_in     = phase_ff;
      k_in         = k_ff;
      noct_in      = noct_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      cz_in = cz_ff;
      mx_in = mx_ff;
      my_in = my_ff;
      mz_in = mz_ff;
      t2_in = t2_ff;
      t3_in = t3_ff;
      fu_in = fu_ff;
      fv_in = fv_ff;
      fw_in = fw_ff;
      hv_in = hv_ff;
      e0_in = e0_ff;
      e1_in = e1_ff;
      e2_in = e2_ff;
      e3_in = e3_ff;
      f0_in = f0_ff;
      f1_in = f1_ff;
      n_in  = n_ff;
      sum_in = sum_ff;

      if (csr_wr_en) begin
         case (csr_index)
            fgn_pkg::CSR_DIMENSION_MODE:  dim_in     = csr_wdata[0];
            fgn_pkg::CSR_OCTAVE_COUNT:    oct_cfg_in = csr_wdata[fgn_pkg::OCT_CFG_W-1:0];
            fgn_pkg::CSR_START_FREQUENCY: freq_in    = csr_wdata;
            fgn_pkg::CSR_START_AMPLITUDE: amp_in     = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_cmd == fgn_pkg::CMD_EVAL) begin
               cx_in   = req_coord_x;
               cy_in   = req_coord_y;
               cz_in   = req_coord_z;
               step_in = '0;
               phase_in = '0;
               k_in    = '0;
               sum_in  = '0;
               // Clamp the octave count to the supported maximum.
               if ({1'b0, oct_cfg_ff} > 6'(MAX_OCTAVES)) begin
                  noct_in = KW'(MAX_OCTAVES);
               end else begin
                  noct_in = KW'(oct_cfg_ff);
               end
               state_in = (oct_cfg_ff == '0) ? ST_DONE : ST_SCALE;
            end
         end
         ST_SCALE: begin
            case (step_ff)
               4'd0:    mx_in = prod[MW-1:0];
               4'd1:    my_in = prod[MW-1:0];
               default: mz_in = prod[MW-1:0];
            endcase
            if (step_ff == last_scale) begin
               step_in  = '0;
               state_in = ST_FADE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_FADE: begin
            case (phase_ff)
               2'd0: begin
                  t2_in    = prod[FB +: FB];
                  phase_in = 2'd1;
               end
               2'd1: begin
                  t3_in    = prod[FB +: FB];
                  phase_in = 2'd2;
               end
               default: begin
                  case (step_ff)
                     4'd0:    fu_in = prod[FB +: FW];
                     4'd1:    fv_in = prod[FB +: FW];
                     default: fw_in = prod[FB +: FW];
                  endcase
                  phase_in = 2'd0;
                  if (step_ff == last_scale) begin
                     step_in  = '0;
                     state_in = ST_HRD;
                  end else begin
                     step_in = step_ff + 1'b1;
                  end
               end
            endcase
         end
         ST_HRD: begin
            state_in = ST_HWB;
         end
         ST_HWB: begin
            hv_in[step_ff] = perm_q_ff;
            if (step_ff == last_hash) begin
               step_in  = '0;
               state_in = ST_LERP;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = ST_HRD;
            end
         end
         ST_LERP: begin
            if (step_ff == last_lerp) begin
               n_in     = lerp_res;
               step_in  = '0;
               state_in = ST_AMP;
            end else begin
               case (step_ff)
                  4'd0:    e0_in = lerp_res;
                  4'd1:    e1_in = lerp_res;
                  4'd2:    e2_in = lerp_res;
                  4'd3:    e3_in = lerp_res;
                  4'd4:    f0_in = lerp_res;
                  default: f1_in = lerp_res;
               endcase
               step_in = step_ff + 1'b1;
            end
         end
         ST_AMP: begin
            // Weigh by amplitude halved per octave, advance to double frequency.
            sum_in = sum_ff + SW'(prod >>> amp_shamt);
            mx_in  = {mx_ff[MW-2:0], 1'b0};
            my_in  = {my_ff[MW-2:0], 1'b0};
            mz_in  = {mz_ff[MW-2:0], 1'b0};
            k_in   = k_ff + 1'b1;
            state_in = (k_ff + 1'b1 == noct_ff) ? ST_DONE : ST_FADE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               if (sum_ff > fgn_pkg::NOISE_MAX) begin
                  rsp_value_in = fgn_pkg::NOISE_W'(fgn_pkg::NOISE_MAX);
               end else if (sum_ff < fgn_pkg::NOISE_MIN) begin
                  rsp_value_in = fgn_pkg::NOISE_W'(fgn_pkg::NOISE_MIN);
               end else begin
                  rsp_value_in = fgn_pkg::NOISE_W'(sum_ff);
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dim_ff       <= 1'b0;
         oct_cfg_ff   <= fgn_pkg::OCT_CFG_W'(1);
         freq_ff      <= fgn_pkg::CFG_W'(256);
         amp_ff       <= fgn_pkg::CFG_W'(256);
         step_ff      <= '0;
         phase_ff     <= '0;
         k_ff         <= '0;
         noct_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dim_ff       <= dim_in;
         oct_cfg_ff   <= oct_cfg_in;
         freq_ff      <= freq_in;
         amp_ff       <= amp_in;
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         k_ff         <= k_in;
         noct_ff      <= noct_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      cx_ff  <= cx_in;
      cy_ff  <= cy_in;
      cz_ff  <= cz_in;
      mx_ff  <= mx_in;
      my_ff  <= my_in;
      mz_ff  <= mz_in;
      t2_ff  <= t2_in;
      t3_ff  <= t3_in;
      fu_ff  <= fu_in;
      fv_ff  <= fv_in;
      fw_ff  <= fw_in;
      hv_ff  <= hv_in;
      e0_ff  <= e0_in;
      e1_ff  <= e1_in;
      e2_ff  <= e2_in;
      e3_ff  <= e3_in;
      f0_ff  <= f0_in;
      f1_ff  <= f1_in;
      n_ff   <= n_in;
      sum_ff <= sum_in;
   end

endmodule

FILE: design/fgn_checker.sv
`include "assert_macros.svh"

module fgn_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               req_cmd,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [fgn_pkg::NOISE_W-1:0] rsp_noise_value
);

   logic eval_acc;
   logic write_acc;

   assign eval_acc  = req_valid && !req_stall && (req_cmd == fgn_pkg::CMD_EVAL);
   assign write_acc = req_valid && !req_stall && (req_cmd == fgn_pkg::CMD_WRITE);

   // A stalled result word holds.
   `FGN_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                   rsp_valid && $stable(rsp_noise_value))
   // An evaluate word keeps the block busy.
   `FGN_ASSERT_NXT(a_eval_busy, clock, reset, eval_acc, req_stall)
   // A table write completes at once.
   `FGN_ASSERT_NXT(a_write_quick, clock, reset, write_acc, !req_stall)
   // A table write never produces a result word.
   `FGN_ASSERT_NXT(a_write_silent, clock, reset, write_acc && !rsp_valid, !rsp_valid)

endmodule

bind fractal_gradient_noise fgn_checker u_fgn_checker (.*);
